// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro places one labelled concurrent assertion on clk, held off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold in every cycle out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  `ASSERT_CLK(label, (cond), msg)

`endif

// File: sv/oli_pkg.sv
// ----------------------------------------------------------------------------
// oli_pkg
// Shared field widths, codes and controller/datapath bundles for the
// ordered list block.
// ----------------------------------------------------------------------------
`default_nettype none

package oli_pkg;

  // field widths of the request and result words
  localparam int FUNC_W = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int FIDX_W = 6;
  localparam int CNT_W  = 7;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic            load;        // capture the request word
    logic            res_clr;     // clear result registers
    logic            res_st_en;   // load status code
    logic [ST_W-1:0] res_st;
    logic            res_found;   // record a match at the current index
    logic            idx_ld_cnt;  // index <= count
    logic            idx_ld_pos;  // index <= position
    logic            idx_inc;
    logic            idx_dec;
    logic            rd_prev;     // read entry index-1
    logic            rd_next;     // read entry index+1
    logic            rd_cur;      // read entry index
    logic            wr_rdata;    // write read data to entry index
    logic            wr_val;      // write request value to entry index
    logic            cnt_inc;
    logic            cnt_dec;
  } cmd_t;

  // datapath to controller flags
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              pos_gt_cnt;
    logic              pos_ge_cnt;
    logic              full;
    logic              idx_gt_pos;
    logic              idx1_lt_cnt;
    logic              idx_lt_cnt;
    logic              match;
  } stat_t;

endpackage

`default_nettype wire

// File: sv/oli_datapath.sv
// ----------------------------------------------------------------------------
// oli_datapath
// Entry memory, count, scan index and result registers. Moves one entry
// per read/write pair and compares one entry per read.
// ----------------------------------------------------------------------------
`default_nettype none

module oli_datapath #(
  parameter int DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire oli_pkg::cmd_t             cmd,
  output oli_pkg::stat_t                 stat,
  input  wire logic [oli_pkg::FUNC_W-1:0] in_func,
  input  wire logic [oli_pkg::POS_W-1:0]  in_position,
  input  wire logic [oli_pkg::VAL_W-1:0]  in_value,
  output logic [oli_pkg::ST_W-1:0]        res_status,
  output logic                            res_found,
  output logic [oli_pkg::FIDX_W-1:0]      res_found_index,
  output logic [oli_pkg::CNT_W-1:0]       res_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (CW > oli_pkg::POS_W) ? CW : oli_pkg::POS_W;

  logic [oli_pkg::FUNC_W-1:0] func_r;
  logic [oli_pkg::POS_W-1:0]  pos_r;
  logic [oli_pkg::VAL_W-1:0]  val_r;
  logic [CW-1:0]              count_r;
  logic [XW-1:0]              idx_r;
  logic [oli_pkg::VAL_W-1:0]  rdata_r;
  logic [oli_pkg::ST_W-1:0]   status_r;
  logic                       found_r;
  logic [XW-1:0]              fidx_r;

  logic [oli_pkg::VAL_W-1:0]  mem [DEPTH];

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] idx_m1;
  logic [XW-1:0] idx_p1;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  assign pos_x  = XW'(pos_r);
  assign cnt_x  = XW'(count_r);
  assign idx_m1 = idx_r - XW'(1);
  assign idx_p1 = idx_r + XW'(1);

  // flags for the controller
  assign stat.func        = func_r;
  assign stat.pos_gt_cnt  = pos_x > cnt_x;
  assign stat.pos_ge_cnt  = pos_x >= cnt_x;
  assign stat.full        = cnt_x >= XW'(DEPTH);
  assign stat.idx_gt_pos  = idx_r > pos_x;
  assign stat.idx1_lt_cnt = idx_p1 < cnt_x;
  assign stat.idx_lt_cnt  = idx_r < cnt_x;
  assign stat.match       = rdata_r == val_r;

  // read address select
  always_comb begin
    rd_en   = cmd.rd_prev | cmd.rd_next | cmd.rd_cur;
    rd_addr = idx_r[AW-1:0];
    if (cmd.rd_prev) begin
      rd_addr = idx_m1[AW-1:0];
    end else if (cmd.rd_next) begin
      rd_addr = idx_p1[AW-1:0];
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (cmd.wr_rdata) begin
      mem[idx_r[AW-1:0]] <= rdata_r;
    end else if (cmd.wr_val) begin
      mem[idx_r[AW-1:0]] <= val_r;
    end
  end

  // request word capture and scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      pos_r  <= in_position;
      val_r  <= in_value;
    end
    if (cmd.idx_ld_cnt) begin
      idx_r <= cnt_x;
    end else if (cmd.idx_ld_pos) begin
      idx_r <= pos_x;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_p1;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_m1;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - CW'(1);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.res_clr) begin
      status_r <= oli_pkg::ST_OK;
      found_r  <= 1'b0;
      fidx_r   <= '0;
    end else begin
      if (cmd.res_st_en) begin
        status_r <= cmd.res_st;
      end
      if (cmd.res_found) begin
        found_r <= 1'b1;
        fidx_r  <= idx_r;
      end
    end
  end

  assign res_status      = status_r;
  assign res_found       = found_r;
  assign res_found_index = fidx_r[oli_pkg::FIDX_W-1:0];
  assign res_entry_count = cnt_x[oli_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

// File: sv/oli_ctrl.sv
// ----------------------------------------------------------------------------
// oli_ctrl
// Sequencer for insert, erase and find: decodes the request, steps the
// shift or scan loop one entry at a time and issues the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module oli_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire oli_pkg::stat_t stat,
  output oli_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                done
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_INS_RD,
    S_INS_WR,
    S_ERA_RD,
    S_ERA_WR,
    S_FND_RD,
    S_FND_CMP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   done_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.res_clr = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.func)
          oli_pkg::FUNC_INSERT: begin
            if (stat.pos_gt_cnt) begin
              cmd.res_st_en = 1'b1;
              cmd.res_st    = oli_pkg::ST_RANGE;
              state_nxt     = S_DONE;
            end else if (stat.full) begin
              cmd.res_st_en = 1'b1;
              cmd.res_st    = oli_pkg::ST_FULL;
              state_nxt     = S_DONE;
            end else begin
              cmd.idx_ld_cnt = 1'b1;
              state_nxt      = S_INS_RD;
            end
          end
          oli_pkg::FUNC_ERASE: begin
            if (stat.pos_ge_cnt) begin
              cmd.res_st_en = 1'b1;
              cmd.res_st    = oli_pkg::ST_RANGE;
              state_nxt     = S_DONE;
            end else begin
              cmd.idx_ld_pos = 1'b1;
              state_nxt      = S_ERA_RD;
            end
          end
          oli_pkg::FUNC_FIND: begin
            cmd.idx_ld_pos = 1'b1;
            state_nxt      = S_FND_RD;
          end
          default: begin
            // unused code: no change, plain ok result
            state_nxt = S_DONE;
          end
        endcase
      end
      S_INS_RD: begin
        if (stat.idx_gt_pos) begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_INS_WR;
        end else begin
          cmd.wr_val  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd.wr_rdata = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_nxt    = S_INS_RD;
      end
      S_ERA_RD: begin
        if (stat.idx1_lt_cnt) begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_ERA_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_ERA_WR: begin
        cmd.wr_rdata = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_ERA_RD;
      end
      S_FND_RD: begin
        if (stat.idx_lt_cnt) begin
          cmd.rd_cur = 1'b1;
          state_nxt  = S_FND_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FND_CMP: begin
        if (stat.match) begin
          cmd.res_found = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_FND_RD;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= state_nxt != S_IDLE;
      done_r  <= state_nxt == S_DONE;
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

`default_nettype wire

// File: sv/ordered_list_insert_erase_find.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_erase_find
// Packed list of signed words with positional insert and erase and a
// forward search, built as a sequencer over a single-port entry memory.
// ----------------------------------------------------------------------------
// Insert shifts count-position words up one place, erase shifts count-position-1
// words down one place, and a find scans forward from position until a match or
// the end of the list; an error or an unused code goes straight to the result.
// Each moved word is one memory read and one write; each compared word one read.
// A new word can be taken in the cycle after the strobe; the receiver cannot stall it.
// Synchronous reset empties the list; contents are not cleared.
`default_nettype none

`include "assert_macros.svh"

module ordered_list_insert_erase_find #(
  parameter int DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [oli_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [oli_pkg::POS_W-1:0]   in_position,
  input  wire logic signed [oli_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  output logic [oli_pkg::ST_W-1:0]         out_status,
  output logic                             out_found,
  output logic [oli_pkg::FIDX_W-1:0]       out_found_index,
  output logic [oli_pkg::CNT_W-1:0]        out_entry_count
);

  oli_pkg::cmd_t  cmd;
  oli_pkg::stat_t stat;

  // sequencer
  oli_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start & ~busy),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  // storage and compare
  oli_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_value        (in_value),
    .res_status      (out_status),
    .res_found       (out_found),
    .res_found_index (out_found_index),
    .res_entry_count (out_entry_count)
  );

  // an accepted word keeps the block busy in the next cycle
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  // one strobe per word, then back to idle
  `ASSERT_CLK(a_strobe_single, out_valid |=> (!out_valid && !busy), "strobe not single")
  // a failed request leaves the count alone
  `ASSERT_CLK(a_err_count, (out_valid && out_status != oli_pkg::ST_OK) |->
    (out_entry_count == $past(out_entry_count)), "count moved on error")
  // a match is only reported with an ok status
  `ASSERT_ALWAYS(a_found_ok, !(out_valid && out_found && out_status != oli_pkg::ST_OK),
    "found with error status")

endmodule

`default_nettype wire
